// ===== hdl/utf8_to_utf16_transcoder_defines.svh =====
// Assertion macros for the UTF-8 to UTF-16 transcoder.
// Expects clk and arst_n in the scope of use; empty under SYNTHESIS.
`ifndef UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH
`define UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH
`ifndef SYNTHESIS
`define U8U16_ASSERT(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("u8u16 check failed");
`define U8U16_ASSERT_IMP(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error("u8u16 check failed");
`define U8U16_ASSERT_NEXT(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("u8u16 check failed");
`else
`define U8U16_ASSERT(label, expr)
`define U8U16_ASSERT_IMP(label, cond, expr)
`define U8U16_ASSERT_NEXT(label, cond, expr)
`endif
`endif

// ===== hdl/u8u16_pkg.sv =====
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
// No dependencies.
package u8u16_pkg;

	localparam logic [12:0] MAX_UNITS     = 13'd4096;
	localparam logic [12:0] CAP_RESET     = 13'd4096;
	localparam int          Q_DEPTH       = 4;
	localparam int          Q_AW          = $clog2(Q_DEPTH);

	localparam logic [7:0]  ASCII_LIMIT   = 8'h80;
	localparam logic [7:0]  LEAD2_MIN     = 8'hC2;
	localparam logic [7:0]  LEAD3_MIN     = 8'hE0;
	localparam logic [7:0]  LEAD4_MIN     = 8'hF0;
	localparam logic [15:0] OVL_LIMIT2    = 16'h007F;
	localparam logic [15:0] OVL_LIMIT3    = 16'h07FF;
	localparam logic [15:0] OVL_LIMIT4    = 16'hFFFF;
	localparam logic [20:0] BMP_MAX       = 21'h00FFFF;
	localparam logic [20:0] CODE_MAX      = 21'h10FFFF;
	localparam logic [20:0] SUPP_BASE     = 21'h010000;
	localparam logic [15:0] HI_SURR_BASE  = 16'hD800;
	localparam logic [15:0] LO_SURR_BASE  = 16'hDC00;

	typedef enum logic [1:0] {
		ST_DATA  = 2'd0,
		ST_END   = 2'd1,
		ST_ERROR = 2'd2
	} status_t;

	typedef struct packed {
		status_t     status;
		logic        pair;
		logic [20:0] value;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} head_t;

endpackage

// ===== hdl/u8u16_byte_if.sv =====
// Byte channel of the transcoder: valid/ready handshake with one UTF-8 byte.
// No dependencies.
interface u8u16_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

// ===== hdl/u8u16_unit_if.sv =====
// Unit channel of the transcoder: valid/ready handshake with one UTF-16 result.
// No dependencies.
interface u8u16_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic [1:0]  status;
	logic        last_of_run;

	modport source (output valid, output code_unit, output status, output last_of_run,
		input ready);
	modport sink (input valid, input code_unit, input status, input last_of_run,
		output ready);
endinterface

// ===== hdl/u8u16_front.sv =====
// Front end: accepts bytes, runs the UTF-8 decode and capacity checks, pushes work entries.
// Depends on u8u16_pkg and u8u16_byte_if.
module u8u16_front
	import u8u16_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [12:0]   cfg_wr_data,
	u8u16_byte_if.sink    utf8,
	input  logic          q_full,
	output push_t         push
);

	logic [12:0] cap_q;
	logic [20:0] accum_q, accum_d;
	logic [1:0]  pending_q, pending_d;
	logic [15:0] limit_q, limit_d;
	logic [12:0] units_q, units_d;
	logic        dropping_q, dropping_d;

	logic        take;
	logic        fail;
	logic [7:0]  b;
	logic [12:0] cap;
	logic [13:0] units_plus2;
	logic [20:0] acc_shift;

	assign utf8.ready  = !q_full;
	assign take        = utf8.valid && !q_full;
	assign b           = utf8.in_byte;
	assign cap         = (cap_q > MAX_UNITS) ? MAX_UNITS : cap_q;
	assign units_plus2 = {1'b0, units_q} + 14'd2;
	assign acc_shift   = {accum_q[14:0], b[5:0]};

	always_comb begin
		accum_d           = accum_q;
		pending_d         = pending_q;
		limit_d           = limit_q;
		units_d           = units_q;
		dropping_d        = dropping_q;
		fail              = 1'b0;
		push.valid        = 1'b0;
		push.entry.status = ST_DATA;
		push.entry.pair   = 1'b0;
		push.entry.value  = '0;
		if (take) begin
			if (dropping_q) begin
				if (b == 8'h00) begin
					dropping_d = 1'b0;
					units_d    = '0;
				end
			end else if (pending_q == 2'd0) begin
				if (b < ASCII_LIMIT) begin
					if (units_q >= cap) begin
						fail = 1'b1;
					end else if (b == 8'h00) begin
						push.valid        = 1'b1;
						push.entry.status = ST_END;
						units_d           = '0;
					end else begin
						push.valid       = 1'b1;
						push.entry.value = {13'd0, b};
						units_d          = units_q + 13'd1;
					end
				end else if (b < LEAD2_MIN) begin
					fail = 1'b1;
				end else if (units_plus2 > {1'b0, cap}) begin
					fail = 1'b1;
				end else if (b >= LEAD4_MIN) begin
					accum_d   = {18'd0, b[2:0]};
					limit_d   = OVL_LIMIT4;
					pending_d = 2'd3;
				end else if (b >= LEAD3_MIN) begin
					accum_d   = {17'd0, b[3:0]};
					limit_d   = OVL_LIMIT3;
					pending_d = 2'd2;
				end else begin
					accum_d   = {16'd0, b[4:0]};
					limit_d   = OVL_LIMIT2;
					pending_d = 2'd1;
				end
			end else begin
				if (b < ASCII_LIMIT) begin
					fail = 1'b1;
				end else begin
					accum_d   = acc_shift;
					pending_d = pending_q - 2'd1;
					if (pending_q == 2'd1) begin
						if (acc_shift <= {5'd0, limit_q} || acc_shift > CODE_MAX) begin
							fail = 1'b1;
						end else if (acc_shift > BMP_MAX) begin
							push.valid       = 1'b1;
							push.entry.pair  = 1'b1;
							push.entry.value = acc_shift;
							units_d          = units_plus2[12:0];
						end else begin
							push.valid       = 1'b1;
							push.entry.value = acc_shift;
							units_d          = units_q + 13'd1;
						end
					end
				end
			end
			if (fail) begin
				push.valid        = 1'b1;
				push.entry.status = ST_ERROR;
				push.entry.pair   = 1'b0;
				push.entry.value  = '0;
				accum_d           = '0;
				pending_d         = '0;
				limit_d           = '0;
				units_d           = '0;
				dropping_d        = (b != 8'h00);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q      <= CAP_RESET;
			accum_q    <= '0;
			pending_q  <= '0;
			limit_q    <= '0;
			units_q    <= '0;
			dropping_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			accum_q    <= accum_d;
			pending_q  <= pending_d;
			limit_q    <= limit_d;
			units_q    <= units_d;
			dropping_q <= dropping_d;
		end
	end

endmodule

// ===== hdl/u8u16_queue.sv =====
// Short work queue between front and back end, one entry per decoded character, end byte or error.
// Depends on u8u16_pkg.
module u8u16_queue
	import u8u16_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	input  logic  pop,
	output logic  full,
	output head_t head
);

	entry_t          mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;
	logic            do_pop;

	assign full       = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push.valid && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push.valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/u8u16_back.sv =====
// Back end: splits supplementary code points into surrogate pairs, drives the output register.
// Depends on u8u16_pkg and u8u16_unit_if.
module u8u16_back
	import u8u16_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  head_t         head,
	output logic          pop,
	u8u16_unit_if.source  utf16
);

	logic        valid_q;
	logic [15:0] unit_q;
	status_t     status_q;
	logic        last_q;
	logic        phase_q;

	logic        load;
	logic [20:0] offs;
	logic [15:0] hi_unit;
	logic [15:0] lo_unit;

	assign load    = !valid_q || utf16.ready;
	assign pop     = load && head.valid && (!head.entry.pair || phase_q);
	assign offs    = head.entry.value - SUPP_BASE;
	assign hi_unit = HI_SURR_BASE + {6'd0, offs[19:10]};
	assign lo_unit = LO_SURR_BASE + {6'd0, offs[9:0]};

	assign utf16.valid       = valid_q;
	assign utf16.code_unit   = unit_q;
	assign utf16.status      = status_q;
	assign utf16.last_of_run = last_q;

	always_ff @(posedge clk) begin
		if (load && head.valid) begin
			status_q <= head.entry.status;
			if (head.entry.pair && !phase_q) begin
				unit_q <= hi_unit;
				last_q <= 1'b0;
			end else begin
				unit_q <= head.entry.pair ? lo_unit : head.entry.value[15:0];
				last_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			valid_q <= head.valid;
			if (head.valid) begin
				phase_q <= head.entry.pair && !phase_q;
			end
		end
	end

endmodule

// ===== hdl/utf8_to_utf16_transcoder.sv =====
// UTF-8 to UTF-16 transcoder top level: front decoder, four-entry queue, back end.
// An accepted byte reaches utf16 through the queue and then the output register.
// Throughput: one byte per cycle while the queue is not full; a surrogate pair makes two beats
// and the four-entry queue between decoder and output register absorbs the extra beat.
// Reset (arst_n low, asynchronous): queue empty, decoder idle, capacity 4096.
// Depends on u8u16_pkg, both channel interfaces, the defines header, u8u16_front, u8u16_queue and u8u16_back.
`include "utf8_to_utf16_transcoder_defines.svh"
module utf8_to_utf16_transcoder
	import u8u16_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [12:0]   cfg_wr_data,
	u8u16_byte_if.sink    utf8,
	u8u16_unit_if.source  utf16
);

	push_t push;
	head_t head;
	logic  pop;
	logic  q_full;

	u8u16_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.utf8        (utf8),
		.q_full      (q_full),
		.push        (push)
	);

	u8u16_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	u8u16_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.utf16  (utf16)
	);

	`U8U16_ASSERT_IMP(a_push_on_beat, push.valid, utf8.valid && utf8.ready)
	`U8U16_ASSERT_IMP(a_error_shape, utf16.valid && utf16.status == ST_ERROR, utf16.last_of_run && utf16.code_unit == 16'h0000)
	`U8U16_ASSERT_IMP(a_high_half, utf16.valid && !utf16.last_of_run, utf16.status == ST_DATA && utf16.code_unit[15:10] == 6'b110110)
	`U8U16_ASSERT_NEXT(a_low_follows, utf16.valid && utf16.ready && !utf16.last_of_run, utf16.valid && utf16.last_of_run && utf16.code_unit[15:10] == 6'b110111)

endmodule

// ===== test/u8u16_transcode_monitor.sv =====
// Watches both channels of the UTF-8 to UTF-16 transcoder, predicts every unit beat
// from the accepted bytes and the capacity writes, and compares beat by beat.
// Depends on u8u16_pkg, u8u16_byte_if and u8u16_unit_if.
module u8u16_transcode_monitor
	import u8u16_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [12:0] cfg_wr_data,
	u8u16_byte_if       utf8,
	u8u16_unit_if       utf16,
	output int          mismatches,
	output int          awaiting,
	output int          bytes_decoded,
	output int          units_seen,
	output int          pairs_seen,
	output int          errors_seen,
	output int          ends_seen
);

	typedef struct packed {
		logic [15:0] code_unit;
		status_t     status;
		logic        last_of_run;
	} utf16_beat_t;

	utf16_beat_t units_due[$];
	logic [12:0] capacity;
	logic [20:0] code_accum;
	logic [1:0]  bytes_pending;
	logic [15:0] overlong_limit;
	logic [12:0] units_written;
	logic        dropping;

	task automatic queue_unit(input logic [15:0] code, input status_t st, input logic last);
		units_due.push_back(utf16_beat_t'{code, st, last});
	endtask

	task automatic flag_error(input logic [7:0] b);
		queue_unit(16'h0000, ST_ERROR, 1'b1);
		code_accum = '0;
		bytes_pending = '0;
		overlong_limit = '0;
		units_written = '0;
		dropping = (b != 8'h00);
	endtask

	task automatic decode_byte(input logic [7:0] b);
		logic [12:0] room;
		logic [20:0] offset;
		room = (capacity > MAX_UNITS) ? MAX_UNITS : capacity;
		if (dropping) begin
			if (b == 8'h00) begin
				dropping = 1'b0;
				units_written = '0;
			end
		end else if (bytes_pending == 2'd0) begin
			if (b < ASCII_LIMIT) begin
				if (units_written >= room) begin
					flag_error(b);
				end else if (b == 8'h00) begin
					queue_unit(16'h0000, ST_END, 1'b1);
					units_written = '0;
				end else begin
					queue_unit({8'h00, b}, ST_DATA, 1'b1);
					units_written = units_written + 13'd1;
				end
			end else if (b < LEAD2_MIN || {1'b0, units_written} + 14'd2 > {1'b0, room}) begin
				flag_error(b);
			end else if (b >= LEAD4_MIN) begin
				code_accum = {18'd0, b[2:0]};
				overlong_limit = OVL_LIMIT4;
				bytes_pending = 2'd3;
			end else if (b >= LEAD3_MIN) begin
				code_accum = {17'd0, b[3:0]};
				overlong_limit = OVL_LIMIT3;
				bytes_pending = 2'd2;
			end else begin
				code_accum = {16'd0, b[4:0]};
				overlong_limit = OVL_LIMIT2;
				bytes_pending = 2'd1;
			end
		end else if (b < ASCII_LIMIT) begin
			flag_error(b);
		end else begin
			code_accum = {code_accum[14:0], b[5:0]};
			bytes_pending = bytes_pending - 2'd1;
			if (bytes_pending == 2'd0) begin
				if (code_accum <= {5'd0, overlong_limit} || code_accum > CODE_MAX) begin
					flag_error(b);
				end else if (code_accum > BMP_MAX) begin
					offset = code_accum - SUPP_BASE;
					queue_unit(HI_SURR_BASE + {6'd0, offset[19:10]}, ST_DATA, 1'b0);
					queue_unit(LO_SURR_BASE + {6'd0, offset[9:0]}, ST_DATA, 1'b1);
					units_written = units_written + 13'd2;
				end else begin
					queue_unit(code_accum[15:0], ST_DATA, 1'b1);
					units_written = units_written + 13'd1;
				end
			end
		end
	endtask

	task automatic check_beat();
		utf16_beat_t seen;
		utf16_beat_t due;
		seen = utf16_beat_t'{utf16.code_unit, status_t'(utf16.status), utf16.last_of_run};
		units_seen++;
		if (seen.status == ST_ERROR)
			errors_seen++;
		if (seen.status == ST_END)
			ends_seen++;
		if (seen.status == ST_DATA && !seen.last_of_run)
			pairs_seen++;
		if (units_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected unit beat: unit %h status %0d last %0b",
					seen.code_unit, seen.status, seen.last_of_run);
		end else begin
			due = units_due.pop_front();
			if (seen !== due) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unit mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
						due.code_unit, due.status, due.last_of_run,
						seen.code_unit, seen.status, seen.last_of_run);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			units_due.delete();
			capacity = CAP_RESET;
			code_accum = '0;
			bytes_pending = '0;
			overlong_limit = '0;
			units_written = '0;
			dropping = 1'b0;
			mismatches = 0;
			awaiting = 0;
			bytes_decoded = 0;
			units_seen = 0;
			pairs_seen = 0;
			errors_seen = 0;
			ends_seen = 0;
		end else begin
			if (cfg_wr_en)
				capacity = cfg_wr_data;
			if (utf8.valid && utf8.ready) begin
				bytes_decoded++;
				decode_byte(utf8.in_byte);
			end
			if (utf16.valid && utf16.ready)
				check_beat();
			awaiting = units_due.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
// Drives the UTF-8 to UTF-16 transcoder with directed strings, then random strings,
// broken sequences and noise under a range of output capacities, and gives the verdict.
// Depends on u8u16_pkg, both channel interfaces, the transcoder and u8u16_transcode_monitor.
module tb_top;
	import u8u16_pkg::*;

	localparam int RANDOM_BYTES  = 1350;
	localparam int RUNS_PER_CAP  = 20;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT   = 600000;

	localparam logic [7:0] DIRECTED [28] = '{
		8'h7F, 8'h01, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hED, 8'hA0, 8'h80,
		8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h00,
		8'hC1, 8'h41, 8'h00,
		8'hE0, 8'h9F, 8'hBF, 8'h00,
		8'hC2, 8'h41, 8'h00,
		8'hE2, 8'h82, 8'h00
	};

	typedef enum int {
		FLAW_BAD_LEAD,
		FLAW_SHORT,
		FLAW_OVERLONG,
		FLAW_TOO_BIG
	} flaw_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [12:0] cfg_wr_data;

	u8u16_byte_if utf8 ();
	u8u16_unit_if utf16 ();

	int mismatches, awaiting, bytes_decoded, units_seen, pairs_seen, errors_seen, ends_seen;
	int cycles = 0;
	int cap_writes = 0;
	bit send_idle;
	bit take_idle;
	bit hold_req;

	always #5 clk = ~clk;

	utf8_to_utf16_transcoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.utf8        (utf8),
		.utf16       (utf16)
	);

	u8u16_transcode_monitor watch (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.utf8          (utf8),
		.utf16         (utf16),
		.mismatches    (mismatches),
		.awaiting      (awaiting),
		.bytes_decoded (bytes_decoded),
		.units_seen    (units_seen),
		.pairs_seen    (pairs_seen),
		.errors_seen   (errors_seen),
		.ends_seen     (ends_seen)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = send_idle ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			utf8.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		utf8.valid <= 1'b1;
		utf8.in_byte <= b;
		do @(posedge clk); while (!utf8.ready);
	endtask

	// encode cp in len bytes whether or not that is the shortest form; send the first count
	task automatic send_coded(input int cp, input int len, input int count);
		logic [7:0] seq [4];
		case (len)
			1: seq[0] = cp[7:0];
			2: begin
				seq[0] = {3'b110, cp[10:6]};
				seq[1] = {2'b10, cp[5:0]};
			end
			3: begin
				seq[0] = {4'b1110, cp[15:12]};
				seq[1] = {2'b10, cp[11:6]};
				seq[2] = {2'b10, cp[5:0]};
			end
			default: begin
				seq[0] = {5'b11110, cp[20:18]};
				seq[1] = {2'b10, cp[17:12]};
				seq[2] = {2'b10, cp[11:6]};
				seq[3] = {2'b10, cp[5:0]};
			end
		endcase
		for (int i = 0; i < count; i++)
			send_byte(seq[i]);
	endtask

	function automatic int pick_code(input int len);
		case (len)
			1: return $urandom_range(1, 'h7F);
			2: return $urandom_range('h80, 'h7FF);
			3: return $urandom_range('h800, 'hFFFF);
			default: return $urandom_range('h10000, 'h10FFFF);
		endcase
	endfunction

	task automatic send_chars(input int n);
		int len;
		repeat (n) begin
			len = $urandom_range(1, 4);
			send_coded(pick_code(len), len, len);
		end
	endtask

	task automatic send_broken_run();
		int len;
		send_chars($urandom_range(0, 3));
		case (flaw_t'($urandom_range(0, 3)))
			FLAW_BAD_LEAD: send_byte(8'($urandom_range('h80, 'hC1)));
			FLAW_SHORT: begin
				len = $urandom_range(2, 4);
				send_coded(pick_code(len), len, $urandom_range(1, len - 1));
				send_byte(8'($urandom_range(0, 'h7F)));
			end
			FLAW_OVERLONG: begin
				len = $urandom_range(2, 4);
				send_coded($urandom_range(0, len == 2 ? 'h7F : len == 3 ? 'h7FF : 'hFFFF),
					len, len);
			end
			default: begin
				if ($urandom_range(0, 1)) begin
					send_coded($urandom_range('h110000, 'h1FFFFF), 4, 4);
				end else begin
					send_byte(8'($urandom_range('hF8, 'hFF)));
					repeat (3) send_byte(8'($urandom_range('h80, 'hFF)));
				end
			end
		endcase
		repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(1, 'h7F)));
		send_byte(8'h00);
	endtask

	task automatic send_noise_run();
		repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 1))
			send_byte(8'h00);
	endtask

	task automatic settle();
		utf8.valid <= 1'b0;
		do @(posedge clk); while (awaiting != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [12:0] cap);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= cap;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cap_writes++;
	endtask

	function automatic logic [12:0] capacity_for(input int phase);
		case (phase)
			0: return 13'd0;
			1: return 13'd1;
			2: return 13'h1FFF;
			3: return 13'd2;
			4: return MAX_UNITS;
			5: return 13'd4097;
			6: return 13'd3;
			default: return 13'($urandom_range(1, 24));
		endcase
	endfunction

	initial begin : unit_sink
		int stall;
		utf16.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				utf16.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				stall = take_idle ? $urandom_range(0, 10) : 0;
				if (stall > 0) begin
					utf16.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			utf16.ready <= 1'b1;
			do @(posedge clk); while (!utf16.valid);
		end
	end

	initial begin : byte_source
		int target;
		int runs;
		int phase;
		int pick;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= CAP_RESET;
		utf8.valid <= 1'b0;
		utf8.in_byte <= 8'h00;
		send_idle = 1'b1;
		take_idle = 1'b1;
		hold_req = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			send_byte(DIRECTED[i]);

		// fill the block behind a long receiver hold
		settle();
		target = bytes_decoded + RANDOM_BYTES;
		send_idle = 1'b0;
		hold_req = 1'b1;
		runs = 0;
		phase = 0;
		while (bytes_decoded < target) begin
			if (runs == RUNS_PER_CAP) begin
				set_capacity(capacity_for(phase));
				phase++;
				runs = 0;
				send_idle = ($urandom_range(0, 3) != 0);
				take_idle = ($urandom_range(0, 3) != 0);
				if (phase == 4)
					hold_req = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				send_chars($urandom_range(0, 8));
				send_byte(8'h00);
			end else if (pick < 85) begin
				send_broken_run();
			end else begin
				send_noise_run();
			end
			runs++;
		end

		settle();
		$display("covered %0d accepted bytes and %0d unit beats: %0d surrogate pairs,",
			bytes_decoded, units_seen, pairs_seen);
		$display("%0d ends, %0d errors, over %0d capacity writes in %0d cycles",
			ends_seen, errors_seen, cap_writes, cycles);
		if (mismatches == 0 && awaiting == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/u8u16_pkg.sv
hdl/u8u16_byte_if.sv
hdl/u8u16_unit_if.sv
hdl/u8u16_front.sv
hdl/u8u16_queue.sv
hdl/u8u16_back.sv
hdl/utf8_to_utf16_transcoder.sv
test/u8u16_transcode_monitor.sv
test/tb_top.sv
